// File: hw/rtl/esbrlc_pkg.sv
// ----------------------------------------------------------------------------
// esbrlc_pkg: shared types and constants of the receiver link controller
// Request and result layouts, command, action and source codes, header masks.
// ----------------------------------------------------------------------------
`default_nettype none

package esbrlc_pkg;

	localparam int unsigned SLOT_W       = 4;
	localparam int unsigned S_TDATA_W    = 64;
	localparam int unsigned S_TUSER_W    = 2;
	localparam int unsigned M_TDATA_W    = 40;
	localparam int unsigned M_TUSER_W    = 2;

	localparam logic [1:0] CMD_RADIO_END = 2'd0;
	localparam logic [1:0] CMD_PUSH      = 2'd1;
	localparam logic [1:0] CMD_RELEASE   = 2'd2;

	localparam logic [1:0] ACT_RESTART   = 2'd0;
	localparam logic [1:0] ACT_TRANSMIT  = 2'd1;
	localparam logic [1:0] ACT_RECEIVE   = 2'd2;
	localparam logic [1:0] ACT_HOST_DONE = 2'd3;

	localparam logic [1:0] SRC_ACK       = 2'd0;
	localparam logic [1:0] SRC_SVC       = 2'd1;
	localparam logic [1:0] SRC_RING      = 2'd2;

	localparam logic [7:0] HDR_MASK      = 8'hf3;
	localparam logic [7:0] SVC_MARK      = 8'h05;
	localparam logic [7:0] UP_BIT        = 8'h08;
	localparam logic [7:0] DOWN_BIT      = 8'h04;
	localparam logic [5:0] SVC_SIZE      = 6'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        crc_ok;
		logic        is_unicast;
		logic [1:0]  pkt_pid;
		logic [15:0] pkt_crc;
		logic [5:0]  pkt_size;
		logic [7:0]  rx_byte0;
		logic [7:0]  rx_byte1;
		logic [7:0]  rx_byte2;
		logic [7:0]  push_header;
	} item_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [1:0]        tx_source;
		logic [SLOT_W-1:0] tx_slot;
		logic [7:0]        tx_byte0;
		logic [7:0]        tx_byte1;
		logic [7:0]        tx_byte2;
		logic [SLOT_W-1:0] rx_slot;
		logic              rx_committed;
		logic              rx_ready;
		logic              tx_room;
		logic              safelink_on;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/esbrlc_ram.sv
// ----------------------------------------------------------------------------
// esbrlc_ram: generic memory
// One write port and two registered read ports; a read of the address being
// written returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module esbrlc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
		rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
	end

endmodule

`default_nettype wire

// File: hw/rtl/esbrlc_ctrl.sv
// ----------------------------------------------------------------------------
// esbrlc_ctrl: link decision logic and link state
// Ring indices, retry detection, sequence bits and service reply state, with
// the single-pass decision for the request held in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module esbrlc_ctrl
	import esbrlc_pkg::*;
#(
	parameter int unsigned RX_RING_DEPTH = 16,
	parameter int unsigned TX_RING_DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             fire,
	input  wire item_t                            item,
	output result_t                               res,
	output logic                                  mem_we,
	output logic [$clog2(TX_RING_DEPTH)-1:0]      mem_waddr,
	output logic [7:0]                            mem_wdata,
	output logic [$clog2(TX_RING_DEPTH)-1:0]      mem_raddr_a,
	output logic [$clog2(TX_RING_DEPTH)-1:0]      mem_raddr_b,
	input  wire logic [7:0]                       mem_rdata_a,
	input  wire logic [7:0]                       mem_rdata_b
);

	localparam int unsigned RX_IW = $clog2(RX_RING_DEPTH);
	localparam int unsigned TX_IW = $clog2(TX_RING_DEPTH);

	function automatic logic [RX_IW-1:0] rx_inc(input logic [RX_IW-1:0] v);
		return (v == RX_IW'(RX_RING_DEPTH - 1)) ? '0 : RX_IW'(v + 1'b1);
	endfunction

	function automatic logic [TX_IW-1:0] tx_inc(input logic [TX_IW-1:0] v);
		return (v == TX_IW'(TX_RING_DEPTH - 1)) ? '0 : TX_IW'(v + 1'b1);
	endfunction

	logic [RX_IW-1:0] rx_wr_q, rx_rd_q, rx_wr_n, rx_rd_n;
	logic [TX_IW-1:0] tx_wr_q, tx_rd_q, tx_wr_n, tx_rd_n;
	logic             trans_q, trans_n;
	logic             up_q, up_n, down_q, down_n;
	logic             safe_q, safe_n;
	logic [1:0]       last_pid_q, last_pid_n;
	logic [15:0]      last_crc_q, last_crc_n;
	logic [1:0]       last_src_q, last_src_n;
	logic [7:0]       last_hdr_q, last_hdr_n;
	logic             svc_pend_q, svc_pend_n;
	logic [23:0]      svc_bytes_q, svc_bytes_n;

	logic             do_retire, do_fresh, do_emit, svc_set, want_we;
	logic [7:0]       hdr_raw, hdr_fresh;
	logic [TX_IW-1:0] rd_eff;

	always_comb begin
		rx_wr_n     = rx_wr_q;
		rx_rd_n     = rx_rd_q;
		tx_wr_n     = tx_wr_q;
		tx_rd_n     = tx_rd_q;
		trans_n     = trans_q;
		up_n        = up_q;
		down_n      = down_q;
		safe_n      = safe_q;
		last_pid_n  = last_pid_q;
		last_crc_n  = last_crc_q;
		last_src_n  = last_src_q;
		last_hdr_n  = last_hdr_q;
		svc_pend_n  = svc_pend_q;
		svc_bytes_n = svc_bytes_q;
		do_retire   = 1'b0;
		do_fresh    = 1'b0;
		do_emit     = 1'b0;
		svc_set     = 1'b0;
		want_we     = 1'b0;
		mem_waddr   = tx_wr_q;
		mem_wdata   = item.push_header;
		hdr_raw     = mem_rdata_a;
		hdr_fresh   = mem_rdata_a;
		res         = '0;
		res.action  = ACT_HOST_DONE;

		case (item.cmd)
			CMD_PUSH: begin
				if (tx_inc(tx_wr_q) != tx_rd_q) begin
					want_we = 1'b1;
					tx_wr_n = tx_inc(tx_wr_q);
				end
			end
			CMD_RELEASE: begin
				if (rx_rd_q != rx_wr_q) begin
					rx_rd_n = rx_inc(rx_rd_q);
				end
			end
			CMD_RADIO_END: begin
				if (trans_q) begin
					trans_n    = 1'b0;
					res.action = ACT_RECEIVE;
				end else if (!item.crc_ok || rx_inc(rx_wr_q) == rx_rd_q) begin
					res.action = ACT_RESTART;
				end else if (!item.is_unicast) begin
					rx_wr_n          = rx_inc(rx_wr_q);
					res.rx_committed = 1'b1;
					res.action       = ACT_RECEIVE;
				end else begin
					last_pid_n = item.pkt_pid;
					last_crc_n = item.pkt_crc;
					res.action = ACT_TRANSMIT;
					if (item.pkt_pid == last_pid_q && item.pkt_crc == last_crc_q) begin
						do_emit = 1'b1;
					end else if (item.pkt_size == SVC_SIZE
							&& (item.rx_byte0 & HDR_MASK) == HDR_MASK
							&& item.rx_byte1 == SVC_MARK) begin
						do_retire   = 1'b1;
						safe_n      = (item.rx_byte2 != 8'd0);
						svc_bytes_n = {item.rx_byte2, item.rx_byte1, item.rx_byte0};
						svc_set     = 1'b1;
						do_fresh    = 1'b1;
						down_n      = 1'b1;
						up_n        = 1'b1;
					end else begin
						if (!safe_q || (item.rx_byte0 & UP_BIT) != {4'd0, up_q, 3'd0}) begin
							rx_wr_n          = rx_inc(rx_wr_q);
							up_n             = ~up_q;
							res.rx_committed = 1'b1;
						end
						if (!safe_q || (item.rx_byte0 & DOWN_BIT) != {5'd0, down_q, 2'd0}) begin
							down_n    = ~down_q;
							do_retire = 1'b1;
							do_fresh  = 1'b1;
						end else begin
							do_emit = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase

		if (do_retire) begin
			if (last_src_q == SRC_RING && tx_rd_q != tx_wr_q) begin
				tx_rd_n = tx_inc(tx_rd_q);
			end
			if (last_src_q == SRC_SVC) begin
				svc_pend_n = 1'b0;
			end
		end
		if (svc_set) begin
			svc_pend_n = 1'b1;
		end

		if (do_fresh) begin
			if (svc_pend_n) begin
				last_src_n = SRC_SVC;
				last_hdr_n = svc_bytes_n[7:0];
			end else if (tx_rd_n != tx_wr_q) begin
				hdr_raw   = (tx_rd_n != tx_rd_q) ? mem_rdata_b : mem_rdata_a;
				hdr_fresh = safe_n ? ((hdr_raw & HDR_MASK) | {5'd0, down_n, 2'd0}) : hdr_raw;
				if (safe_n) begin
					want_we   = 1'b1;
					mem_waddr = tx_rd_n;
					mem_wdata = hdr_fresh;
				end
				last_src_n = SRC_RING;
				last_hdr_n = hdr_fresh;
			end else begin
				last_src_n = SRC_ACK;
				last_hdr_n = HDR_MASK | {5'd0, down_n, 2'd0};
			end
		end

		if (do_fresh || do_emit) begin
			trans_n       = 1'b1;
			res.tx_source = last_src_n;
			res.tx_slot   = (last_src_n == SRC_RING) ? SLOT_W'(tx_rd_n) : '0;
			res.tx_byte0  = last_hdr_n;
			if (last_src_n == SRC_SVC) begin
				res.tx_byte1 = svc_bytes_n[15:8];
				res.tx_byte2 = svc_bytes_n[23:16];
			end
		end

		res.rx_slot     = SLOT_W'(rx_wr_n);
		res.rx_ready    = (rx_wr_n != rx_rd_n);
		res.tx_room     = (tx_inc(tx_wr_n) != tx_rd_n);
		res.safelink_on = safe_n;
	end

	// The read ports follow the head of the transmit ring and the slot after it.
	assign rd_eff      = fire ? tx_rd_n : tx_rd_q;
	assign mem_raddr_a = rd_eff;
	assign mem_raddr_b = tx_inc(rd_eff);
	assign mem_we      = fire && want_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wr_q     <= '0;
			rx_rd_q     <= '0;
			tx_wr_q     <= '0;
			tx_rd_q     <= '0;
			trans_q     <= 1'b0;
			up_q        <= 1'b1;
			down_q      <= 1'b1;
			safe_q      <= 1'b0;
			last_pid_q  <= '0;
			last_crc_q  <= '0;
			last_src_q  <= SRC_ACK;
			last_hdr_q  <= '0;
			svc_pend_q  <= 1'b0;
			svc_bytes_q <= '0;
		end else if (fire) begin
			rx_wr_q     <= rx_wr_n;
			rx_rd_q     <= rx_rd_n;
			tx_wr_q     <= tx_wr_n;
			tx_rd_q     <= tx_rd_n;
			trans_q     <= trans_n;
			up_q        <= up_n;
			down_q      <= down_n;
			safe_q      <= safe_n;
			last_pid_q  <= last_pid_n;
			last_crc_q  <= last_crc_n;
			last_src_q  <= last_src_n;
			last_hdr_q  <= last_hdr_n;
			svc_pend_q  <= svc_pend_n;
			svc_bytes_q <= svc_bytes_n;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/esb_receiver_link_controller.sv
// ----------------------------------------------------------------------------
// esb_receiver_link_controller: receiver-side link controller
// Decides drop, queue, acknowledge, resend or service reply for radio events
// and keeps the receive and transmit rings for host pushes and releases.
// A request passes the input register and then the output register; one request
// per cycle while the output is not stalled. The decision for a request is made
// combinationally between the two, with the transmit header store read ahead.
// Reset clears the ring indices and link state; the header store is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module esb_receiver_link_controller
	import esbrlc_pkg::*;
#(
	parameter int unsigned RX_RING_DEPTH = 16,
	parameter int unsigned TX_RING_DEPTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// crc_ok, is_unicast, pkt_pid, pkt_crc, pkt_size, rx_byte0, rx_byte1,
	// rx_byte2, push_header
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// cmd
	input  wire logic [S_TUSER_W-1:0] s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// tx_source, tx_slot, tx_byte0, tx_byte1, tx_byte2, rx_slot, rx_committed,
	// rx_ready, tx_room, safelink_on
	output logic [M_TDATA_W-1:0]      m_tdata,
	// action
	output logic [M_TUSER_W-1:0]      m_tuser
);

	localparam int unsigned TX_IW = $clog2(TX_RING_DEPTH);

	item_t            item_in, item_s1;
	logic             valid_s1;
	logic             fire;
	result_t          res, result_q;
	logic             m_tvalid_q;
	logic             mem_we;
	logic [TX_IW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
	logic [7:0]       mem_wdata, mem_rdata_a, mem_rdata_b;

	always_comb begin
		item_in             = '0;
		item_in.cmd         = s_tuser[1:0];
		item_in.crc_ok      = s_tdata[0];
		item_in.is_unicast  = s_tdata[1];
		item_in.pkt_pid     = s_tdata[3:2];
		item_in.pkt_crc     = s_tdata[19:4];
		item_in.pkt_size    = s_tdata[25:20];
		item_in.rx_byte0    = s_tdata[33:26];
		item_in.rx_byte1    = s_tdata[41:34];
		item_in.rx_byte2    = s_tdata[49:42];
		item_in.push_header = s_tdata[57:50];
	end

	assign fire     = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

	esbrlc_ctrl #(
		.RX_RING_DEPTH(RX_RING_DEPTH),
		.TX_RING_DEPTH(TX_RING_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr_a(mem_raddr_a),
		.mem_raddr_b(mem_raddr_b),
		.mem_rdata_a(mem_rdata_a),
		.mem_rdata_b(mem_rdata_b)
	);

	esbrlc_ram #(
		.WIDTH(8),
		.DEPTH(TX_RING_DEPTH)
	) u_hdr_store (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr_a(mem_raddr_a),
		.rdata_a(mem_rdata_a),
		.raddr_b(mem_raddr_b),
		.rdata_b(mem_rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = result_q.action;
	assign m_tdata  = {2'b00,
			result_q.safelink_on, result_q.tx_room, result_q.rx_ready,
			result_q.rx_committed, result_q.rx_slot,
			result_q.tx_byte2, result_q.tx_byte1, result_q.tx_byte0,
			result_q.tx_slot, result_q.tx_source};

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
			(valid_s1 && m_tvalid_q && !m_tready) |=> valid_s1)
		else $error("Input register lost a request while the output was stalled.");

	a_no_send_fields: assert property (@(posedge clk) disable iff (!arst_n)
			(m_tvalid_q && result_q.action != ACT_TRANSMIT) |->
			(result_q.tx_source == SRC_ACK && result_q.tx_byte0 == 8'd0))
		else $error("Transmit fields are set on a result that sends nothing.");

	a_commit_action: assert property (@(posedge clk) disable iff (!arst_n)
			(m_tvalid_q && result_q.rx_committed) |->
			(result_q.action == ACT_TRANSMIT || result_q.action == ACT_RECEIVE))
		else $error("A packet was committed on a result that drops it.");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
			$rose(m_tvalid_q) |-> $past(valid_s1))
		else $error("A result appeared without a request in the input register.");

endmodule

`default_nettype wire
